/* rtl/sha1md_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the SHA-1 digest engine.
package sha1md_pkg;

    localparam int LengthBitsDefault = 64;
    localparam int WordW             = 32;
    localparam int NumWords          = 5;
    localparam int BlockWords        = 16;
    localparam int Rounds            = 80;
    localparam int LenFieldBits      = 64;
    localparam int RoundCntW         = $clog2(Rounds);
    localparam int WordIdxW          = 3;
    localparam int ByteCntW          = 6;

    localparam logic [7:0] PadMark = 8'h80;

    // Message beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } sha1md_in_t;

    // Digest beat
    typedef struct packed {
        logic [WordW-1:0]    digest_word;
        logic [WordIdxW-1:0] word_index;
        logic                last_word;
    } sha1md_out_t;

    // Source of the byte shifted into the block buffer
    typedef enum logic [1:0] {
        BSRC_DATA = 2'd0,
        BSRC_MARK = 2'd1,
        BSRC_ZERO = 2'd2,
        BSRC_LEN  = 2'd3
    } sha1md_bsrc_t;

    // Controller to datapath commands
    typedef struct packed {
        logic         absorb;
        sha1md_bsrc_t bsrc;
        logic         round_en;
        logic         chain_add;
        logic         word_next;
    } sha1md_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic cnt_last;
        logic cnt_len;
        logic round_last;
        logic word_last;
    } sha1md_stat_t;

    // Initial chaining value
    function automatic logic [WordW-1:0] sha1md_iv(input logic [WordIdxW-1:0] idx);
        logic [WordW-1:0] v;
        case (idx)
            3'd0:    v = 32'h67452301;
            3'd1:    v = 32'hEFCDAB89;
            3'd2:    v = 32'h98BADCFE;
            3'd3:    v = 32'h10325476;
            default: v = 32'hC3D2E1F0;
        endcase
        return v;
    endfunction

    // Round constant for rounds 0..79
    function automatic logic [WordW-1:0] sha1md_k(input logic [RoundCntW-1:0] t);
        logic [WordW-1:0] v;
        if (t < RoundCntW'(20)) begin
            v = 32'h5A827999;
        end else if (t < RoundCntW'(40)) begin
            v = 32'h6ED9EBA1;
        end else if (t < RoundCntW'(60)) begin
            v = 32'h8F1BBCDC;
        end else begin
            v = 32'hCA62C1D6;
        end
        return v;
    endfunction

endpackage

/* rtl/sha1md_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for message absorb, padding, compression and digest output.
module sha1md_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   msg_valid,
    input  logic                   has_byte,
    input  logic                   end_of_message,
    output logic                   msg_stall,
    output logic                   digest_valid,
    input  logic                   digest_stall,
    input  sha1md_pkg::sha1md_stat_t stat,
    output sha1md_pkg::sha1md_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MARK = 7'b0000010,
        ST_ZERO = 7'b0000100,
        ST_FILL = 7'b0001000,
        ST_COMP = 7'b0010000,
        ST_CADD = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    state_t resume_reg, resume_next;

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        resume_next = resume_reg;
        cmd         = '0;
        cmd.bsrc    = sha1md_pkg::BSRC_DATA;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid) begin
                    cmd.absorb = has_byte;
                    if (has_byte && stat.cnt_last) begin
                        state_next  = ST_COMP;
                        resume_next = end_of_message ? ST_MARK : ST_IDLE;
                    end else if (end_of_message) begin
                        state_next = ST_MARK;
                    end
                end
            end
            ST_MARK:
            begin
                cmd.absorb = 1'b1;
                cmd.bsrc   = sha1md_pkg::BSRC_MARK;
                if (stat.cnt_last) begin
                    state_next  = ST_COMP;
                    resume_next = ST_FILL;
                end else if (stat.cnt_len) begin
                    state_next = ST_ZERO;
                end else begin
                    state_next = ST_FILL;
                end
            end
            ST_ZERO:
            begin
                // no room for the length: zero out the rest of this block
                cmd.absorb = 1'b1;
                cmd.bsrc   = sha1md_pkg::BSRC_ZERO;
                if (stat.cnt_last) begin
                    state_next  = ST_COMP;
                    resume_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                cmd.absorb = 1'b1;
                cmd.bsrc   = stat.cnt_len ? sha1md_pkg::BSRC_LEN : sha1md_pkg::BSRC_ZERO;
                if (stat.cnt_last) begin
                    state_next  = ST_COMP;
                    resume_next = ST_EMIT;
                end
            end
            ST_COMP:
            begin
                cmd.round_en = 1'b1;
                if (stat.round_last) begin
                    state_next = ST_CADD;
                end
            end
            ST_CADD:
            begin
                cmd.chain_add = 1'b1;
                state_next    = resume_reg;
            end
            ST_EMIT:
            begin
                if (!digest_stall) begin
                    cmd.word_next = 1'b1;
                    if (stat.word_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            resume_reg <= ST_IDLE;
        end else begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
        end
    end

    assign msg_stall    = (state_reg != ST_IDLE);
    assign digest_valid = (state_reg == ST_EMIT);

    // A closing beat always leaves idle
    a_close_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && !msg_stall && end_of_message |=> state_reg != ST_IDLE)
        else $error("closing beat did not start padding");

    // Never take a message beat while a digest is offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(digest_valid && !msg_stall))
        else $error("message accepted during digest output");

    // Chain update only right after the last round
    a_add_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CADD |-> $past(state_reg) == ST_COMP)
        else $error("chain update without compression");

endmodule

/* rtl/sha1md_dp.sv */
`timescale 1ns / 1ps
// Block buffer, round datapath, chaining value and length counter.
module sha1md_dp #(
    parameter int LENGTH_BITS = sha1md_pkg::LengthBitsDefault
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [7:0]              data_byte,
    input  sha1md_pkg::sha1md_cmd_t  cmd,
    output sha1md_pkg::sha1md_stat_t stat,
    output sha1md_pkg::sha1md_out_t  digest_beat
);

    localparam int W  = sha1md_pkg::WordW;
    localparam int NW = sha1md_pkg::NumWords;
    localparam int BW = sha1md_pkg::BlockWords;
    localparam int RW = sha1md_pkg::RoundCntW;
    localparam int IW = sha1md_pkg::WordIdxW;
    localparam int CW = sha1md_pkg::ByteCntW;
    localparam int LF = sha1md_pkg::LenFieldBits;

    logic [W-1:0]           w_reg     [BW];
    logic [W-1:0]           work_reg  [NW];
    logic [W-1:0]           work_next [NW];
    logic [W-1:0]           chain_reg [NW];
    logic [CW-1:0]          cnt_reg;
    logic [LENGTH_BITS-1:0] bits_reg;
    logic [RW-1:0]          round_reg;
    logic [IW-1:0]          word_idx_reg;

    logic [LF-1:0] len_field;
    logic [7:0]    byte_in;
    logic [W-1:0]  f_val;
    logic [W-1:0]  w_new;
    logic [W-1:0]  tmp;
    logic          do_clear;

    assign do_clear = cmd.word_next && stat.word_last;

    // Select the byte to shift in
    assign len_field = LF'(bits_reg);
    always_comb
    begin
        case (cmd.bsrc)
            sha1md_pkg::BSRC_DATA: byte_in = data_byte;
            sha1md_pkg::BSRC_MARK: byte_in = sha1md_pkg::PadMark;
            sha1md_pkg::BSRC_LEN:  byte_in = len_field[{~cnt_reg[2:0], 3'b000} +: 8];
            default:               byte_in = 8'h00;
        endcase
    end

    // Round function
    always_comb
    begin
        if (round_reg < RW'(20)) begin
            f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
        end else if (round_reg < RW'(40)) begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
        end else if (round_reg < RW'(60)) begin
            f_val = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3])
                  | (work_reg[2] & work_reg[3]);
        end else begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
        end
    end

    assign w_new = {w_reg[13][W-2:0] ^ w_reg[8][W-2:0] ^ w_reg[2][W-2:0] ^ w_reg[0][W-2:0],
                    w_reg[13][W-1] ^ w_reg[8][W-1] ^ w_reg[2][W-1] ^ w_reg[0][W-1]};
    assign tmp   = {work_reg[0][W-6:0], work_reg[0][W-1:W-5]} + f_val + work_reg[4]
                 + sha1md_pkg::sha1md_k(round_reg) + w_reg[0];

    always_comb
    begin
        work_next[0] = tmp;
        work_next[1] = work_reg[0];
        work_next[2] = {work_reg[1][1:0], work_reg[1][W-1:2]};
        work_next[3] = work_reg[2];
        work_next[4] = work_reg[3];
    end

    // Block buffer: byte shift while loading, word shift while compressing
    always_ff @(posedge clk)
    begin
        if (cmd.absorb) begin
            for (int i = 0; i < BW - 1; i++) begin
                w_reg[i] <= {w_reg[i][W-9:0], w_reg[i+1][W-1:W-8]};
            end
            w_reg[BW-1] <= {w_reg[BW-1][W-9:0], byte_in};
        end else if (cmd.round_en) begin
            for (int i = 0; i < BW - 1; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[BW-1] <= w_new;
        end
    end

    // Working variables and chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NW; i++) begin
                work_reg[i]  <= sha1md_pkg::sha1md_iv(IW'(i));
                chain_reg[i] <= sha1md_pkg::sha1md_iv(IW'(i));
            end
        end else if (do_clear) begin
            for (int i = 0; i < NW; i++) begin
                work_reg[i]  <= sha1md_pkg::sha1md_iv(IW'(i));
                chain_reg[i] <= sha1md_pkg::sha1md_iv(IW'(i));
            end
        end else if (cmd.chain_add) begin
            for (int i = 0; i < NW; i++) begin
                work_reg[i]  <= chain_reg[i] + work_reg[i];
                chain_reg[i] <= chain_reg[i] + work_reg[i];
            end
        end else if (cmd.round_en) begin
            for (int i = 0; i < NW; i++) begin
                work_reg[i] <= work_next[i];
            end
        end
    end

    // Counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg      <= '0;
            bits_reg     <= '0;
            round_reg    <= '0;
            word_idx_reg <= '0;
        end else begin
            if (do_clear) begin
                cnt_reg  <= '0;
                bits_reg <= '0;
            end else if (cmd.absorb) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cmd.bsrc == sha1md_pkg::BSRC_DATA) begin
                    bits_reg <= bits_reg + LENGTH_BITS'(8);
                end
            end
            if (cmd.round_en && !stat.round_last) begin
                round_reg <= round_reg + RW'(1);
            end else begin
                round_reg <= '0;
            end
            if (do_clear) begin
                word_idx_reg <= '0;
            end else if (cmd.word_next) begin
                word_idx_reg <= word_idx_reg + IW'(1);
            end
        end
    end

    assign stat.cnt_last   = (cnt_reg == '1);
    assign stat.cnt_len    = (cnt_reg[CW-1:3] == '1);
    assign stat.round_last = (round_reg == RW'(sha1md_pkg::Rounds - 1));
    assign stat.word_last  = (word_idx_reg == IW'(NW - 1));

    assign digest_beat.digest_word = chain_reg[word_idx_reg];
    assign digest_beat.word_index  = word_idx_reg;
    assign digest_beat.last_word   = stat.word_last;

    // Round counter only runs during compression
    a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.round_en |=> round_reg == '0)
        else $error("round counter moved outside compression");

    // Digest word index stays in range
    a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
        word_idx_reg <= IW'(NW - 1))
        else $error("digest word index out of range");

endmodule

/* rtl/sha1_message_digest.sv */
`timescale 1ns / 1ps
// A message beat is taken when the sequencer is idle; a beat that fills a 64-byte block
// then holds the input through 80 rounds plus one chain update. Closing: the pad
// mark, zero bytes and the length field are shifted in, with one or two compressions,
// then five digest beats, one per cycle without stall. No message byte is taken while
// the single round unit compresses a block. Reset loads the SHA-1 initial chain value
// and clears byte and bit counts; the block buffer is not cleared.
module sha1_message_digest #(
    parameter int LENGTH_BITS = sha1md_pkg::LengthBitsDefault
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    msg_valid,
    output logic                    msg_stall,
    input  sha1md_pkg::sha1md_in_t  msg_beat,
    output logic                    digest_valid,
    input  logic                    digest_stall,
    output sha1md_pkg::sha1md_out_t digest_beat
);

    sha1md_pkg::sha1md_cmd_t  cmd;
    sha1md_pkg::sha1md_stat_t stat;

    // Sequencer
    sha1md_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg_valid      (msg_valid),
        .has_byte       (msg_beat.has_byte),
        .end_of_message (msg_beat.end_of_message),
        .msg_stall      (msg_stall),
        .digest_valid   (digest_valid),
        .digest_stall   (digest_stall),
        .stat           (stat),
        .cmd            (cmd)
    );

    // Datapath
    sha1md_dp #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (msg_beat.data_byte),
        .cmd         (cmd),
        .stat        (stat),
        .digest_beat (digest_beat)
    );

endmodule
